// ----- design/sliding_window_distinct_count_assert.svh -----
// Assertion macros for the sliding window distinct counter checker.
// Each macro expands to one labeled concurrent assertion that reports via $error.
`ifndef SLIDING_WINDOW_DISTINCT_COUNT_ASSERT_SVH
`define SLIDING_WINDOW_DISTINCT_COUNT_ASSERT_SVH

// Same-cycle implication: whenever a holds, c holds too.
`define SWDC_ASSERT_IMPL(label, clk, dis, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |-> (c)) else $error(msg);

// Next-cycle implication: whenever a holds, c holds in the cycle after.
`define SWDC_ASSERT_NEXT(label, clk, dis, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |=> (c)) else $error(msg);

`endif

// ----- design/swdc_pkg.sv -----
// Shared constants, payload structs and command structs for the distinct counter.
// No dependencies; every design module imports this package.
package swdc_pkg;

    localparam int VALUE_BITS = 8;
    localparam int WINDOW_MAX = 64;

    // Fixed field widths of the two channels and the config register.
    localparam int SAMPLE_W   = 8;
    localparam int DCOUNT_W   = 7;
    localparam int WLEN_W     = 7;
    localparam int WLEN_RESET = 4;

    localparam int VALUE_SPAN = 1 << VALUE_BITS;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
    localparam int CNT_W      = FILL_W;

    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OCC_W      = $clog2(OUT_DEPTH + 1);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic                stream_end;
    } in_item_t;

    typedef struct packed {
        logic [DCOUNT_W-1:0] distinct_count;
        logic                window_full;
    } out_item_t;

    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        value_t           wr_data;
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
    } ring_cmd_t;

    typedef struct packed {
        logic   rd_en;
        value_t rd_addr;
        logic   wr_en;
        value_t wr_addr;
        cnt_t   wr_data;
        logic   clear;
    } cnt_cmd_t;

    // Zero acts as one, anything past the ring depth acts as the ring depth.
    function automatic logic [FILL_W-1:0] eff_len(input logic [WLEN_W-1:0] wlen);
        if (wlen == '0) begin
            return FILL_W'(1);
        end
        if (int'(wlen) > WINDOW_MAX) begin
            return FILL_W'(WINDOW_MAX);
        end
        return FILL_W'(wlen);
    endfunction

endpackage

// ----- design/swdc_ring_ram.sv -----
// Sample ring: one write port and one registered read port.
// Depends on swdc_pkg for the ring depth and the command struct.
module swdc_ring_ram (
    input  logic                aclk,
    input  swdc_pkg::ring_cmd_t cmd,
    output swdc_pkg::value_t    rd_data
);
    import swdc_pkg::*;

    value_t mem [WINDOW_MAX];
    value_t rd_data_reg;

    // Read returns the old contents when both ports hit the same slot.
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/swdc_count_table.sv -----
// Per-value occurrence counts: memory with live bits and a one-entry write bypass.
// Depends on swdc_pkg for the value span, count width and command struct.
module swdc_count_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  swdc_pkg::cnt_cmd_t cmd,
    output swdc_pkg::cnt_t     rd_count
);
    import swdc_pkg::*;

    cnt_t                  mem [VALUE_SPAN];
    logic [VALUE_SPAN-1:0] live_reg;
    cnt_t                  rd_data_reg;
    logic                  rd_live_reg;
    value_t                rd_addr_reg;
    logic                  byp_valid_reg;
    value_t                byp_addr_reg;
    cnt_t                  byp_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= cmd.wr_data;
            byp_addr_reg     <= cmd.wr_addr;
            byp_data_reg     <= cmd.wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cmd.rd_addr];
            rd_addr_reg <= cmd.rd_addr;
        end
    end

    // Clear drops every live bit at once; a dead entry reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg      <= '0;
            rd_live_reg   <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else if (cmd.clear) begin
            live_reg      <= '0;
            rd_live_reg   <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else begin
            if (cmd.wr_en) begin
                live_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.rd_en) begin
                rd_live_reg <= live_reg[cmd.rd_addr];
            end
            byp_valid_reg <= cmd.wr_en;
        end
    end

    // Forward a write that landed on the same edge as the read.
    assign rd_count = (byp_valid_reg && (byp_addr_reg == rd_addr_reg)) ? byp_data_reg :
                      (rd_live_reg ? rd_data_reg : '0);

endmodule

// ----- design/swdc_out_fifo.sv -----
// Result queue between the count pipeline and the result channel.
// Depends on swdc_pkg for the queue depth and the result struct.
module swdc_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  swdc_pkg::out_item_t push_data,
    output logic                m_valid,
    input  logic                m_ready,
    output swdc_pkg::out_item_t m_data
);
    import swdc_pkg::*;

    out_item_t            slot_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0]     level_reg, level_next;
    logic                 pop;

    assign m_valid = (level_reg != '0);
    assign m_data  = slot_mem[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg + OCC_W'(push) - OCC_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ----- design/sliding_window_distinct_count.sv -----
// Top level of the sliding window distinct counter: ring, count table, result queue.
// Depends on swdc_pkg, swdc_ring_ram, swdc_count_table and swdc_out_fifo.
//
//   channel   ports                         moves
//   config    cfg_wr_en, cfg_wr_data        window length, write on enable
//   input     s_valid, s_ready, s_data      one sample per transfer
//   result    m_valid, m_ready, m_data      one distinct count per transfer
//
// Eviction and insertion each do a read-modify-write on the single port pair of
// the count table, so s_ready stays low while an item is in p1. A result passes
// the p1, p2 and p3 registers and the result queue before it is valid. Reset, a
// config write and stream end clear the table's live bits at once, with no
// clearing pass. Up to four items may be in flight or queued; s_ready drops when four are.
module sliding_window_distinct_count (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [swdc_pkg::WLEN_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  swdc_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output swdc_pkg::out_item_t         m_data
);
    import swdc_pkg::*;

    typedef struct packed {
        value_t sample;
        logic   evict;
        logic   full;
        logic   last;
    } stage_t;

    logic [FILL_W-1:0]   len_reg;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [DCOUNT_W-1:0] distinct_reg, distinct_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic                p1_valid_reg, p2_valid_reg, p3_valid_reg;
    stage_t              p1_reg, p2_reg, p3_reg;
    value_t              p2_old_reg;

    logic                accept;
    logic                pop;
    logic                evict;
    logic [FILL_W-1:0]   fill_after;
    logic [FILL_W:0]     back;
    logic [PTR_W-1:0]    oldest;
    value_t              sample;
    ring_cmd_t           ring_cmd;
    value_t              ring_rdata;
    cnt_cmd_t            cnt_cmd;
    cnt_t                rd_count;
    logic [DCOUNT_W-1:0] result_count;
    out_item_t           result;

    assign s_ready = !p1_valid_reg && (occ_reg < OCC_W'(OUT_DEPTH));
    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign sample  = value_t'(s_data.sample_value);

    // Window bookkeeping at the input transfer.
    always_comb begin
        evict      = (fill_reg == len_reg);
        fill_after = evict ? fill_reg : fill_reg + 1'b1;
        back       = (FILL_W+1)'(ptr_reg) - (FILL_W+1)'(fill_reg);
        if ((FILL_W+1)'(ptr_reg) < (FILL_W+1)'(fill_reg)) begin
            back = back + (FILL_W+1)'(WINDOW_MAX);
        end
        oldest = back[PTR_W-1:0];

        ptr_next  = ptr_reg;
        fill_next = fill_reg;
        if (accept) begin
            ptr_next  = (ptr_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr_reg + 1'b1;
            fill_next = fill_after;
            if (s_data.stream_end) begin
                ptr_next  = '0;
                fill_next = '0;
            end
        end
        if (cfg_wr_en) begin
            ptr_next  = '0;
            fill_next = '0;
        end
    end

    always_comb begin
        ring_cmd         = '0;
        ring_cmd.wr_en   = accept;
        ring_cmd.wr_addr = ptr_reg;
        ring_cmd.wr_data = sample;
        ring_cmd.rd_en   = accept && evict;
        ring_cmd.rd_addr = oldest;
    end

    // Count table schedule: stage 1 reads the evicted value, stage 2 writes it
    // back decremented and reads the new value, stage 3 writes the new value.
    always_comb begin
        cnt_cmd = '0;
        if (p1_valid_reg && p1_reg.evict) begin
            cnt_cmd.rd_en   = 1'b1;
            cnt_cmd.rd_addr = ring_rdata;
        end
        if (p2_valid_reg) begin
            cnt_cmd.rd_en   = 1'b1;
            cnt_cmd.rd_addr = p2_reg.sample;
            if (p2_reg.evict && (rd_count != '0)) begin
                cnt_cmd.wr_en   = 1'b1;
                cnt_cmd.wr_addr = p2_old_reg;
                cnt_cmd.wr_data = rd_count - CNT_W'(1);
            end
        end
        if (p3_valid_reg) begin
            cnt_cmd.wr_en   = 1'b1;
            cnt_cmd.wr_addr = p3_reg.sample;
            cnt_cmd.wr_data = rd_count + CNT_W'(1);
        end
        cnt_cmd.clear = cfg_wr_en || (p3_valid_reg && p3_reg.last);
    end

    always_comb begin
        result_count  = distinct_reg + DCOUNT_W'(rd_count == '0);
        distinct_next = distinct_reg;
        if (p2_valid_reg && p2_reg.evict && (rd_count == CNT_W'(1))
                && (distinct_reg != '0)) begin
            distinct_next = distinct_reg - 1'b1;
        end
        if (p3_valid_reg) begin
            distinct_next = p3_reg.last ? '0 : result_count;
        end
        if (cfg_wr_en) begin
            distinct_next = '0;
        end
        occ_next = occ_reg + OCC_W'(accept) - OCC_W'(pop);

        result.distinct_count = result_count;
        result.window_full    = p3_reg.full;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg.sample <= sample;
            p1_reg.evict  <= evict;
            p1_reg.full   <= (fill_after == len_reg);
            p1_reg.last   <= s_data.stream_end;
        end
        p2_reg     <= p1_reg;
        p2_old_reg <= ring_rdata;
        p3_reg     <= p2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= eff_len(WLEN_W'(WLEN_RESET));
            ptr_reg      <= '0;
            fill_reg     <= '0;
            distinct_reg <= '0;
            occ_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                len_reg <= eff_len(cfg_wr_data);
            end
            ptr_reg      <= ptr_next;
            fill_reg     <= fill_next;
            distinct_reg <= distinct_next;
            occ_reg      <= occ_next;
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    swdc_ring_ram u_ring (
        .aclk    (aclk),
        .cmd     (ring_cmd),
        .rd_data (ring_rdata)
    );

    swdc_count_table u_counts (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cnt_cmd),
        .rd_count (rd_count)
    );

    swdc_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p3_valid_reg),
        .push_data (result),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- design/swdc_checker.sv -----
// Port-level checks for the distinct counter, bound onto the top level.
// Depends on swdc_pkg and the assertion macros in the header.
`include "sliding_window_distinct_count_assert.svh"

module swdc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input swdc_pkg::out_item_t m_data
);
    import swdc_pkg::*;

    // A stalled result holds.
    `SWDC_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // Two table updates per item: no input transfer in the cycle after one.
    `SWDC_ASSERT_NEXT(a_in_gap, aclk, !aresetn, s_valid && s_ready, !s_ready, "input taken on consecutive cycles")

    // Every result counts at least the sample just inserted, at most a full ring.
    `SWDC_ASSERT_IMPL(a_count_range, aclk, !aresetn, m_valid, (m_data.distinct_count != '0) && (m_data.distinct_count <= DCOUNT_W'(WINDOW_MAX)), "distinct count out of range")

    // Reset empties the result queue and opens the input.
    `SWDC_ASSERT_NEXT(a_reset_empty, aclk, 1'b0, !aresetn, !m_valid && s_ready, "block not empty after reset")

endmodule

bind sliding_window_distinct_count swdc_checker u_swdc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
